// File: hdl/itp_pkg.sv
// Package for the timestamp parser: byte positions, characters, register indexes and helpers.
package itp_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned ACC_W    = 7;
  localparam int unsigned MILLIS_W = 10;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_YEAR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_MILLIS = 2'd2;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd0;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd9999;

  // Byte positions within the text
  localparam logic [POS_W-1:0] POS_MONTH   = 5'd4;
  localparam logic [POS_W-1:0] POS_DASH_A  = 5'd4;
  localparam logic [POS_W-1:0] POS_DASH_B  = 5'd7;
  localparam logic [POS_W-1:0] POS_T       = 5'd10;
  localparam logic [POS_W-1:0] POS_COLON_A = 5'd13;
  localparam logic [POS_W-1:0] POS_COLON_B = 5'd16;
  localparam logic [POS_W-1:0] POS_DOT     = 5'd19;
  localparam logic [POS_W-1:0] POS_YEAR_LO = 5'd2;
  localparam logic [POS_W-1:0] SHORT_LEN   = 5'd19;
  localparam logic [POS_W-1:0] LONG_LEN    = 5'd23;
  localparam logic [POS_W-1:0] POS_SAT     = 5'd24;

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_DASH  = 8'h2D;
  localparam logic [7:0] CHR_T     = 8'h54;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_DOT   = 8'h2E;

  localparam logic [ACC_W-1:0] MAX_HOUR = 7'd23;
  localparam logic [ACC_W-1:0] MAX_MIN  = 7'd59;
  localparam logic [ACC_W-1:0] MAX_MON  = 7'd12;

  // Values captured from the last byte, waiting for the range checks
  typedef struct packed {
    logic                fmt_ok;
    logic                long_form;
    logic [YEAR_W-1:0]   year;
    logic [ACC_W-1:0]    year_hi;
    logic [ACC_W-1:0]    year_lo;
    logic [ACC_W-1:0]    month;
    logic [ACC_W-1:0]    day;
    logic [ACC_W-1:0]    hour;
    logic [ACC_W-1:0]    minute;
    logic [ACC_W-1:0]    second;
    logic [MILLIS_W-1:0] millis;
  } fin_t;

  function automatic logic [4:0] month_days(input logic [ACC_W-1:0] month, input logic leap);
    logic [4:0] days;
    case (month)
      7'd2:                       days = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:    days = 5'd30;
      default:                    days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

// File: hdl/iso_timestamp_parser_core.sv
// Timestamp parser: per-byte format check and digit accumulation, then date and time range check.
//
//  Channel | Ports                                          | Direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_ready, in_char_byte, in_end_of_text | in
//  result  | out_valid, out_ready, out_ok, out_*_out, out_has_millis | out
//  config  | cfg_we, cfg_index, cfg_wdata                   | in
//
// One byte is taken per cycle while in_ready is high. The byte marked as last moves its
// accumulated fields into a check register, and from there they pass on to the result
// register, which raises out_valid, as soon as it is free. Synchronous reset clears the parser
// state and loads the register reset values. While out_ready is low the result register and
// the check register each hold one item; bytes keep flowing until the check register is full.
module iso_timestamp_parser_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_char_byte,
  input  logic                          in_end_of_text,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ok,
  output logic [itp_pkg::YEAR_W-1:0]    out_year_out,
  output logic [3:0]                    out_month_out,
  output logic [4:0]                    out_day_out,
  output logic [4:0]                    out_hour_out,
  output logic [5:0]                    out_minute_out,
  output logic [5:0]                    out_second_out,
  output logic [itp_pkg::MILLIS_W-1:0]  out_millis_out,
  output logic                          out_has_millis,
  input  logic                          cfg_we,
  input  logic [itp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [itp_pkg::YEAR_W-1:0]    cfg_wdata
);
  import itp_pkg::*;

  // Configuration
  logic [YEAR_W-1:0] min_year_r;
  logic [YEAR_W-1:0] max_year_r;
  logic              allow_millis_r;

  // Parser state
  logic [POS_W-1:0]    pos_r,    pos_nxt;
  logic                err_r,    err_nxt;
  logic [YEAR_W-1:0]   year_r,   year_nxt;
  logic [ACC_W-1:0]    yhi_r,    yhi_nxt;
  logic [ACC_W-1:0]    ylo_r,    ylo_nxt;
  logic [ACC_W-1:0]    month_r,  month_nxt;
  logic [ACC_W-1:0]    day_r,    day_nxt;
  logic [ACC_W-1:0]    hour_r,   hour_nxt;
  logic [ACC_W-1:0]    minute_r, minute_nxt;
  logic [ACC_W-1:0]    second_r, second_nxt;
  logic [MILLIS_W-1:0] millis_r, millis_nxt;

  logic       fin_valid_r;
  fin_t       fin_r, fin_nxt;
  logic       out_valid_r;
  logic       out_load, fin_free, in_xfer;

  logic       is_digit;
  logic [3:0] dig;
  logic       leap;
  logic [4:0] mdays;
  logic       good;

  assign out_load = !out_valid_r || out_ready;
  assign fin_free = !fin_valid_r || out_load;
  assign in_ready = fin_free;
  assign in_xfer  = in_valid && in_ready;
  assign out_valid = out_valid_r;

  assign is_digit = (in_char_byte >= CHR_ZERO) && (in_char_byte <= CHR_NINE);
  assign dig      = in_char_byte[3:0];

  // Byte check and digit accumulation for the current position
  always_comb begin
    err_nxt    = err_r;
    year_nxt   = year_r;
    yhi_nxt    = yhi_r;
    ylo_nxt    = ylo_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    millis_nxt = millis_r;
    pos_nxt    = (pos_r < POS_SAT) ? pos_r + 5'd1 : pos_r;
    case (pos_r)
      POS_DASH_A, POS_DASH_B: begin
        if (in_char_byte != CHR_DASH) err_nxt = 1'b1;
      end
      POS_T: begin
        if (in_char_byte != CHR_T) err_nxt = 1'b1;
      end
      POS_COLON_A, POS_COLON_B: begin
        if (in_char_byte != CHR_COLON) err_nxt = 1'b1;
      end
      POS_DOT: begin
        if (in_char_byte != CHR_DOT) err_nxt = 1'b1;
      end
      default: begin
        if (pos_r >= LONG_LEN || !is_digit) begin
          err_nxt = 1'b1;
        end else if (pos_r < POS_MONTH) begin
          year_nxt = year_r * 14'd10 + {10'd0, dig};
          if (pos_r < POS_YEAR_LO) begin
            yhi_nxt = yhi_r * 7'd10 + {3'd0, dig};
          end else begin
            ylo_nxt = ylo_r * 7'd10 + {3'd0, dig};
          end
        end else if (pos_r < POS_DASH_B) begin
          month_nxt = month_r * 7'd10 + {3'd0, dig};
        end else if (pos_r < POS_T) begin
          day_nxt = day_r * 7'd10 + {3'd0, dig};
        end else if (pos_r < POS_COLON_A) begin
          hour_nxt = hour_r * 7'd10 + {3'd0, dig};
        end else if (pos_r < POS_COLON_B) begin
          minute_nxt = minute_r * 7'd10 + {3'd0, dig};
        end else if (pos_r < SHORT_LEN) begin
          second_nxt = second_r * 7'd10 + {3'd0, dig};
        end else begin
          millis_nxt = millis_r * 10'd10 + {6'd0, dig};
        end
      end
    endcase
  end

  always_comb begin
    fin_nxt.fmt_ok    = !err_nxt && (pos_nxt == SHORT_LEN || pos_nxt == LONG_LEN);
    fin_nxt.long_form = (pos_nxt == LONG_LEN);
    fin_nxt.year      = year_nxt;
    fin_nxt.year_hi   = yhi_nxt;
    fin_nxt.year_lo   = ylo_nxt;
    fin_nxt.month     = month_nxt;
    fin_nxt.day       = day_nxt;
    fin_nxt.hour      = hour_nxt;
    fin_nxt.minute    = minute_nxt;
    fin_nxt.second    = second_nxt;
    fin_nxt.millis    = millis_nxt;
  end

  // A year is a leap year when its last two digits are a multiple of four, except for a
  // whole century, which needs the first two digits to be a multiple of four.
  assign leap  = (fin_r.year_lo[1:0] == 2'd0) &&
                 ((fin_r.year_lo != 7'd0) || (fin_r.year_hi[1:0] == 2'd0));
  assign mdays = month_days(fin_r.month, leap);

  assign good = fin_r.fmt_ok && (!fin_r.long_form || allow_millis_r) &&
                (fin_r.year >= min_year_r) && (fin_r.year <= max_year_r) &&
                (fin_r.month >= 7'd1) && (fin_r.month <= MAX_MON) &&
                (fin_r.day >= 7'd1) && (fin_r.day <= {2'd0, mdays}) &&
                (fin_r.hour <= MAX_HOUR) && (fin_r.minute <= MAX_MIN) &&
                (fin_r.second <= MAX_MIN);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_year_r     <= MIN_YEAR_RST;
      max_year_r     <= MAX_YEAR_RST;
      allow_millis_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_YEAR:     min_year_r     <= cfg_wdata;
        REG_MAX_YEAR:     max_year_r     <= cfg_wdata;
        REG_ALLOW_MILLIS: allow_millis_r <= cfg_wdata[0];
        default:          ;
      endcase
    end
  end

  // Parser state: cleared after the last byte of each text
  always_ff @(posedge clk) begin
    if (!rst_n || (in_xfer && in_end_of_text)) begin
      pos_r    <= '0;
      err_r    <= 1'b0;
      year_r   <= '0;
      yhi_r    <= '0;
      ylo_r    <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      millis_r <= '0;
    end else if (in_xfer) begin
      pos_r    <= pos_nxt;
      err_r    <= err_nxt;
      year_r   <= year_nxt;
      yhi_r    <= yhi_nxt;
      ylo_r    <= ylo_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      millis_r <= millis_nxt;
    end
  end

  // Check register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (fin_free) begin
      fin_valid_r <= in_xfer && in_end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_free && in_xfer && in_end_of_text) begin
      fin_r <= fin_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= fin_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && fin_valid_r) begin
      out_ok         <= good;
      out_year_out   <= good ? fin_r.year : '0;
      out_month_out  <= good ? fin_r.month[3:0] : '0;
      out_day_out    <= good ? fin_r.day[4:0] : '0;
      out_hour_out   <= good ? fin_r.hour[4:0] : '0;
      out_minute_out <= good ? fin_r.minute[5:0] : '0;
      out_second_out <= good ? fin_r.second[5:0] : '0;
      out_millis_out <= (good && fin_r.long_form) ? fin_r.millis : '0;
      out_has_millis <= good && fin_r.long_form;
    end
  end

endmodule

// File: tb/tb_iso_timestamp_parser_core.sv
// Self-checking testbench for the ISO timestamp parser core with its own predictor and scoreboard.
`timescale 1ns / 100ps

typedef logic [7:0] text_t [$];

typedef struct packed {
  logic                         ok;
  logic [itp_pkg::YEAR_W-1:0]   year;
  logic [3:0]                   month;
  logic [4:0]                   day;
  logic [4:0]                   hour;
  logic [5:0]                   minute;
  logic [5:0]                   second;
  logic [itp_pkg::MILLIS_W-1:0] millis;
  logic                         has_ms;
} stamp_t;

class stamp_checker;
  bit [itp_pkg::YEAR_W-1:0]   min_yr;
  bit [itp_pkg::YEAR_W-1:0]   max_yr;
  bit                         allow_ms;
  bit [itp_pkg::POS_W-1:0]    pos;
  bit                         fmt_err;
  bit [itp_pkg::YEAR_W-1:0]   year_acc;
  bit [itp_pkg::ACC_W-1:0]    mon_acc;
  bit [itp_pkg::ACC_W-1:0]    day_acc;
  bit [itp_pkg::ACC_W-1:0]    hour_acc;
  bit [itp_pkg::ACC_W-1:0]    min_acc;
  bit [itp_pkg::ACC_W-1:0]    sec_acc;
  bit [itp_pkg::MILLIS_W-1:0] ms_acc;
  stamp_t                     awaited_stamps[$];
  int                         errors;
  int                         shown;
  int                         checked;
  int                         valid_seen;

  function new();
    min_yr   = itp_pkg::MIN_YEAR_RST;
    max_yr   = itp_pkg::MAX_YEAR_RST;
    allow_ms = 1'b1;
    clear_text();
  endfunction

  function void clear_text();
    pos      = '0;
    fmt_err  = 1'b0;
    year_acc = '0;
    mon_acc  = '0;
    day_acc  = '0;
    hour_acc = '0;
    min_acc  = '0;
    sec_acc  = '0;
    ms_acc   = '0;
  endfunction

  function int month_len(int y, int m);
    bit leap;
    leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    case (m)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function void set_reg(logic [itp_pkg::CFG_IDX_W-1:0] idx, int value);
    case (idx)
      itp_pkg::REG_MIN_YEAR:     min_yr = value[itp_pkg::YEAR_W-1:0];
      itp_pkg::REG_MAX_YEAR:     max_yr = value[itp_pkg::YEAR_W-1:0];
      itp_pkg::REG_ALLOW_MILLIS: allow_ms = value[0];
      default: ;
    endcase
  endfunction

  function int pending();
    return awaited_stamps.size();
  endfunction

  // Called for every transferred byte; the marked last byte yields one expected stamp.
  function void note_byte(logic [7:0] c, logic last);
    stamp_t r;
    int     d;
    int     acc;
    bit     digit;
    bit     long_form;
    bit     good;
    digit = (c >= itp_pkg::CHR_ZERO) && (c <= itp_pkg::CHR_NINE);
    d = c - itp_pkg::CHR_ZERO;
    if (pos >= itp_pkg::LONG_LEN) begin
      fmt_err = 1'b1;
    end else if (pos == itp_pkg::POS_DASH_A || pos == itp_pkg::POS_DASH_B) begin
      if (c != itp_pkg::CHR_DASH) fmt_err = 1'b1;
    end else if (pos == itp_pkg::POS_T) begin
      if (c != itp_pkg::CHR_T) fmt_err = 1'b1;
    end else if (pos == itp_pkg::POS_COLON_A || pos == itp_pkg::POS_COLON_B) begin
      if (c != itp_pkg::CHR_COLON) fmt_err = 1'b1;
    end else if (pos == itp_pkg::POS_DOT) begin
      if (c != itp_pkg::CHR_DOT) fmt_err = 1'b1;
    end else if (!digit) begin
      fmt_err = 1'b1;
    end else if (pos < itp_pkg::POS_DASH_A) begin
      acc = year_acc * 10 + d;
      year_acc = acc[itp_pkg::YEAR_W-1:0];
    end else if (pos < itp_pkg::POS_DASH_B) begin
      acc = mon_acc * 10 + d;
      mon_acc = acc[itp_pkg::ACC_W-1:0];
    end else if (pos < itp_pkg::POS_T) begin
      acc = day_acc * 10 + d;
      day_acc = acc[itp_pkg::ACC_W-1:0];
    end else if (pos < itp_pkg::POS_COLON_A) begin
      acc = hour_acc * 10 + d;
      hour_acc = acc[itp_pkg::ACC_W-1:0];
    end else if (pos < itp_pkg::POS_COLON_B) begin
      acc = min_acc * 10 + d;
      min_acc = acc[itp_pkg::ACC_W-1:0];
    end else if (pos < itp_pkg::SHORT_LEN) begin
      acc = sec_acc * 10 + d;
      sec_acc = acc[itp_pkg::ACC_W-1:0];
    end else begin
      acc = ms_acc * 10 + d;
      ms_acc = acc[itp_pkg::MILLIS_W-1:0];
    end
    if (pos < itp_pkg::POS_SAT) pos = pos + 1'b1;
    if (!last) return;

    long_form = (pos == itp_pkg::LONG_LEN);
    good = !fmt_err && (pos == itp_pkg::SHORT_LEN || (long_form && allow_ms));
    good = good && year_acc >= min_yr && year_acc <= max_yr;
    good = good && mon_acc >= 1 && mon_acc <= itp_pkg::MAX_MON;
    good = good && day_acc >= 1 && day_acc <= month_len(year_acc, mon_acc);
    good = good && hour_acc <= itp_pkg::MAX_HOUR && min_acc <= itp_pkg::MAX_MIN &&
           sec_acc <= itp_pkg::MAX_MIN;
    r = '0;
    if (good) begin
      r.ok     = 1'b1;
      r.year   = year_acc;
      r.month  = mon_acc[3:0];
      r.day    = day_acc[4:0];
      r.hour   = hour_acc[4:0];
      r.minute = min_acc[5:0];
      r.second = sec_acc[5:0];
      r.millis = long_form ? ms_acc : '0;
      r.has_ms = long_form;
    end
    awaited_stamps.push_back(r);
    clear_text();
  endfunction

  function string show(stamp_t s);
    return $sformatf("ok=%0d %0d-%0d-%0d %0d:%0d:%0d millis=%0d has_millis=%0d", s.ok,
                     s.year, s.month, s.day, s.hour, s.minute, s.second, s.millis, s.has_ms);
  endfunction

  function void check_result(stamp_t got);
    stamp_t exp;
    bit     bad;
    if (awaited_stamps.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("[%0t] result with nothing awaited: %s", $time, show(got));
      end
      return;
    end
    exp = awaited_stamps.pop_front();
    checked++;
    if (exp.ok) valid_seen++;
    bad = (got.ok !== exp.ok) || (got.year !== exp.year) || (got.month !== exp.month) ||
          (got.day !== exp.day) || (got.hour !== exp.hour) ||
          (got.minute !== exp.minute) || (got.second !== exp.second) ||
          (got.millis !== exp.millis) || (got.has_ms !== exp.has_ms);
    if (bad) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("[%0t] mismatch: expected %s", $time, show(exp));
        $display("[%0t]           actual   %s", $time, show(got));
      end
    end
  endfunction

  function void flush_check();
    if (awaited_stamps.size() != 0) begin
      errors += awaited_stamps.size();
      $display("%0d expected results never arrived", awaited_stamps.size());
    end
  endfunction
endclass

module tb_iso_timestamp_parser_core;
  import itp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_GAP   = 4;
  localparam int SEG_BYTES   = 260;
  localparam int LONG_STALL  = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_char_byte;
  logic                  in_end_of_text;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_ok;
  logic [YEAR_W-1:0]     out_year_out;
  logic [3:0]            out_month_out;
  logic [4:0]            out_day_out;
  logic [4:0]            out_hour_out;
  logic [5:0]            out_minute_out;
  logic [5:0]            out_second_out;
  logic [MILLIS_W-1:0]   out_millis_out;
  logic                  out_has_millis;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [YEAR_W-1:0]     cfg_wdata;

  stamp_checker stamps = new();
  int send_idle;
  int recv_idle;
  int stall_req;
  int bytes_sent;
  int cycle_count;

  string directed_txt[$] = {
    "0000-01-01T00:00:00", "0000-02-29T00:00:00", "9999-12-31T23:59:59.999",
    "2024-02-29T12:30:45.000", "1900-02-29T12:00:00", "2000-02-29T12:00:00",
    "2023-02-29T12:00:00", "2021-04-31T08:00:00", "2021-00-10T08:00:00",
    "2021-13-10T08:00:00", "2021-06-00T08:00:00", "2021-06-15T24:00:00",
    "2021-06-15T23:60:00", "2021-06-15T23:59:60", "2021/06/15T23:59:59",
    "2021-06-15 23:59:59", "2021-06-15T23:59:59,123", "2021-06-15T23:59:59.1234567",
    "2021-06-15T23:59:5", "2021-06-15T23:59:59.12", "2021-06-15T23:59:59.1a3"
  };

  iso_timestamp_parser_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_byte   (in_char_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_ok         (out_ok),
    .out_year_out   (out_year_out),
    .out_month_out  (out_month_out),
    .out_day_out    (out_day_out),
    .out_hour_out   (out_hour_out),
    .out_minute_out (out_minute_out),
    .out_second_out (out_second_out),
    .out_millis_out (out_millis_out),
    .out_has_millis (out_has_millis),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic text_t to_bytes(string s);
    text_t t;
    foreach (s[i]) t.push_back(s[i]);
    return t;
  endfunction

  // Mostly well-formed stamps with years biased towards the current window, plus broken
  // stamps and plain noise.
  function automatic text_t make_text(int lo, int hi);
    text_t t;
    int    kind, y, mo, dy, hr, mi, sc, ms, len, k, n, last_pos;
    int    dg[17];
    kind = $urandom_range(99);
    if (kind < 10) begin
      n = $urandom_range(30, 1);
      repeat (n) t.push_back(8'($urandom_range(255)));
      return t;
    end
    case ($urandom_range(4))
      0, 1, 2: y = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(9999);
      3: begin
        case ($urandom_range(3))
          0:       y = lo - 1;
          1:       y = lo;
          2:       y = hi;
          default: y = hi + 1;
        endcase
        if (y < 0) y = 0;
        if (y > 9999) y = 9999;
      end
      default: y = $urandom_range(9999);
    endcase
    mo  = ($urandom_range(9) != 0) ? $urandom_range(12, 1) : $urandom_range(99);
    len = stamps.month_len(y, mo);
    k   = $urandom_range(9);
    if (k < 6) dy = $urandom_range(len, 1);
    else if (k < 8) dy = len;
    else if (k == 8) dy = len + 1;
    else dy = $urandom_range(99);
    hr = ($urandom_range(7) != 0) ? $urandom_range(23) : $urandom_range(99, 24);
    mi = ($urandom_range(7) != 0) ? $urandom_range(59) : $urandom_range(99, 60);
    sc = ($urandom_range(7) != 0) ? $urandom_range(59) : $urandom_range(99, 60);
    ms = $urandom_range(999);
    dg = '{y / 1000 % 10, y / 100 % 10, y / 10 % 10, y % 10, mo / 10, mo % 10,
           dy / 10, dy % 10, hr / 10, hr % 10, mi / 10, mi % 10, sc / 10, sc % 10,
           ms / 100, ms / 10 % 10, ms % 10};
    last_pos = $urandom_range(1) ? LONG_LEN - 1 : SHORT_LEN - 1;
    k = 0;
    for (int p = 0; p <= last_pos; p++) begin
      case (p)
        POS_DASH_A, POS_DASH_B:   t.push_back(CHR_DASH);
        POS_T:                    t.push_back(CHR_T);
        POS_COLON_A, POS_COLON_B: t.push_back(CHR_COLON);
        POS_DOT:                  t.push_back(CHR_DOT);
        default: begin
          t.push_back(CHR_ZERO + 8'(dg[k]));
          k++;
        end
      endcase
    end
    if (kind < 30) begin
      case ($urandom_range(2))
        0: begin
          k = $urandom_range(t.size() - 1);
          t[k] = 8'($urandom_range(255));
        end
        1: begin
          n = $urandom_range(t.size() - 1, 1);
          while (t.size() > n) void'(t.pop_back());
        end
        default: repeat ($urandom_range(8, 1)) t.push_back(CHR_ZERO + 8'($urandom_range(9)));
      endcase
    end
    return t;
  endfunction

  // Valid is left high after a transfer, so the next byte can follow without a bubble.
  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_byte   <= c;
    in_end_of_text <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    stamps.note_byte(c, last);
    bytes_sent++;
  endtask

  task automatic send_text(input text_t t);
    for (int i = 0; i < t.size(); i++) send_byte(t[i], i == t.size() - 1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (stamps.pending() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic program_regs(input int lo, input int hi, input bit ms);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_YEAR;
    cfg_wdata <= YEAR_W'(lo);
    @(posedge clk);
    stamps.set_reg(REG_MIN_YEAR, lo);
    cfg_index <= REG_MAX_YEAR;
    cfg_wdata <= YEAR_W'(hi);
    @(posedge clk);
    stamps.set_reg(REG_MAX_YEAR, hi);
    cfg_index <= REG_ALLOW_MILLIS;
    cfg_wdata <= YEAR_W'(ms);
    @(posedge clk);
    stamps.set_reg(REG_ALLOW_MILLIS, ms);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    text_t t;
    int    seg_start, lo, hi;
    bit    stalled, paused;
    stalled = 1'b0;
    paused  = 1'b0;
    send_idle      = 15;
    recv_idle      = 77;
    stall_req      = 0;
    bytes_sent     = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_char_byte   <= '0;
    in_end_of_text <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_MIN_YEAR;
    cfg_wdata      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_txt[i]) send_text(to_bytes(directed_txt[i]));
    // A NUL in a digit position, and a lone byte with every bit set.
    t = to_bytes("2021-06-15T23:59:59");
    t[2] = 8'h00;
    send_text(t);
    t = {8'hFF};
    send_text(t);
    drain_results();

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin send_idle = 15; recv_idle = 77; end
        1: begin send_idle = 77; recv_idle = 15; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (seg)
        0: program_regs(1900, 2100, 1'b1);
        1: program_regs(0, 9999, 1'b0);
        2: begin
          lo = $urandom_range(9999);
          hi = $urandom_range(9999, lo);
          program_regs(lo, hi, $urandom_range(1));
        end
        3: program_regs(9999, 9999, 1'b1);
        4: program_regs(6000, 3000, 1'b1);
        default: program_regs(0, 0, 1'b0);
      endcase
      seg_start = bytes_sent;
      while (bytes_sent - seg_start < SEG_BYTES) begin
        if (seg == 4 && !stalled && bytes_sent - seg_start > SEG_BYTES / 2) begin
          // The receiver holds off while bytes keep coming, so the core must stall its input.
          stall_req = LONG_STALL;
          stalled = 1'b1;
        end
        if (seg == 3 && !paused && bytes_sent - seg_start > SEG_BYTES / 2) begin
          drain_results();
          paused = 1'b1;
        end
        send_text(make_text(stamps.min_yr, stamps.max_yr));
      end
      drain_results();
    end

    stamps.flush_check();
    $display("Checked %0d timestamps (%0d valid, %0d rejected) from %0d bytes.",
             stamps.checked, stamps.valid_seen, stamps.checked - stamps.valid_seen,
             bytes_sent);
    $display("Six register settings under three throttling patterns, one long output stall.");
    if (stamps.errors == 0) begin
      $display("tb_iso_timestamp_parser_core: PASS");
    end else begin
      $display("tb_iso_timestamp_parser_core: FAIL");
    end
    $finish;
  end

  initial begin : result_sink
    stamp_t got;
    int     hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.ok     = out_ok;
        got.year   = out_year_out;
        got.month  = out_month_out;
        got.day    = out_day_out;
        got.hour   = out_hour_out;
        got.minute = out_minute_out;
        got.second = out_second_out;
        got.millis = out_millis_out;
        got.has_ms = out_has_millis;
        stamps.check_result(got);
      end
      if (stall_req != 0) begin
        hold_left = stall_req;
        stall_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
             stamps.pending());
    $display("tb_iso_timestamp_parser_core: FAIL");
    $finish;
  end

endmodule

// File: sim.f
hdl/itp_pkg.sv
hdl/iso_timestamp_parser_core.sv
tb/tb_iso_timestamp_parser_core.sv
